/* rtl/udrb_pkg.sv */
// Shared types and operation codes for the serial port ring buffer pair.
package udrb_pkg;

   // Operation codes carried in the request transaction
   localparam logic [2:0] OP_RX_PUT    = 3'd0;
   localparam logic [2:0] OP_TX_READY  = 3'd1;
   localparam logic [2:0] OP_TX_PUT    = 3'd2;
   localparam logic [2:0] OP_RX_GET    = 3'd3;
   localparam logic [2:0] OP_RX_CHECK  = 3'd4;
   localparam logic [2:0] OP_CLEAR_ALL = 3'd5;
   localparam logic [2:0] OP_CLEAR_TX  = 3'd6;

   typedef struct packed {
      logic [2:0]  op;
      logic [7:0]  data;
      logic [15:0] wanted_count;
      logic        enable_transmit;
      logic        last_byte;
   } req_type;

   typedef struct packed {
      logic       byte_valid;
      logic [7:0] out_byte;
      logic [7:0] rx_available;
      logic       enough_bytes;
      logic       tx_idle;
   } rsp_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic capture;  // latch the request and read both rings
      logic commit;   // carry out the operation and load the result register
   } ctrl_cmd_type;

endpackage

/* rtl/udrb_if.sv */
// Valid/ready channel interfaces for request and response transactions.
interface udrb_req_if;
   logic               valid;
   logic               ready;
   udrb_pkg::req_type  payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface udrb_rsp_if;
   logic               valid;
   logic               ready;
   udrb_pkg::rsp_type  payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/udrb_controller.sv */
// Controller state machine: sequences capture and commit, owns response valid.
module udrb_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output udrb_pkg::ctrl_cmd_type  cmd
);
   import udrb_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic state_ff;
   logic state_in;
   logic rsp_valid_ff;
   logic rsp_valid_in;

   // Decide commands and next state
   always_comb begin
      state_in    = state_ff;
      cmd.capture = 1'b0;
      cmd.commit  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // hold until the result register is free or being drained
            cmd.commit = !rsp_valid_ff || rsp_ready;
            if (cmd.commit) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Load on commit, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

/* rtl/udrb_datapath.sv */
// Datapath: ring memories, pointers, transmit enable flag and result register.
module udrb_datapath #(
   parameter int RX_DEPTH = 256,
   parameter int TX_DEPTH = 256
) (
   input  logic                    clock,
   input  logic                    reset,
   input  udrb_pkg::ctrl_cmd_type  cmd,
   input  udrb_pkg::req_type       req_payload,
   output udrb_pkg::rsp_type       rsp_payload
);
   import udrb_pkg::*;

   localparam int RX_AW  = $clog2(RX_DEPTH);
   localparam int TX_AW  = $clog2(TX_DEPTH);
   localparam int RX_CW  = $clog2(RX_DEPTH + 1);
   localparam int CMP_W  = (RX_CW > 16) ? RX_CW : 16;
   localparam logic [RX_AW-1:0] RX_LAST = RX_AW'(RX_DEPTH - 1);
   localparam logic [TX_AW-1:0] TX_LAST = TX_AW'(TX_DEPTH - 1);
   localparam logic [RX_CW-1:0] RX_SIZE = RX_CW'(RX_DEPTH);

   logic [7:0] rx_mem [RX_DEPTH];
   logic [7:0] tx_mem [TX_DEPTH];

   req_type          req_ff;
   logic [7:0]       rx_rd_ff;
   logic [7:0]       tx_rd_ff;
   logic [RX_AW-1:0] rx_wp_ff, rx_wp_in, rx_rp_ff, rx_rp_in;
   logic [TX_AW-1:0] tx_wp_ff, tx_wp_in, tx_rp_ff, tx_rp_in;
   logic [RX_AW-1:0] rx_wp_inc, rx_rp_inc;
   logic [TX_AW-1:0] tx_wp_inc, tx_rp_inc;
   logic             irq_en_ff, irq_en_in;
   logic [RX_CW-1:0] rx_count;
   rsp_type          rsp_ff, rsp_in;

   // Latch the request and read both rings at the read pointers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff   <= req_payload;
         rx_rd_ff <= rx_mem[rx_rp_ff];
         tx_rd_ff <= tx_mem[tx_rp_ff];
      end
   end

   // Store queued and received bytes at the write pointers
   always_ff @(posedge clock) begin
      if (cmd.commit && (req_ff.op == OP_RX_PUT)) begin
         rx_mem[rx_wp_ff] <= req_ff.data;
      end
      if (cmd.commit && (req_ff.op == OP_TX_PUT)) begin
         tx_mem[tx_wp_ff] <= req_ff.data;
      end
   end

   // Advance pointers with wrap at the ring depth
   assign rx_wp_inc = (rx_wp_ff == RX_LAST) ? '0 : rx_wp_ff + RX_AW'(1);
   assign rx_rp_inc = (rx_rp_ff == RX_LAST) ? '0 : rx_rp_ff + RX_AW'(1);
   assign tx_wp_inc = (tx_wp_ff == TX_LAST) ? '0 : tx_wp_ff + TX_AW'(1);
   assign tx_rp_inc = (tx_rp_ff == TX_LAST) ? '0 : tx_rp_ff + TX_AW'(1);

   // Carry out the operation
   always_comb begin
      rx_wp_in            = rx_wp_ff;
      rx_rp_in            = rx_rp_ff;
      tx_wp_in            = tx_wp_ff;
      tx_rp_in            = tx_rp_ff;
      irq_en_in           = irq_en_ff;
      rsp_in.byte_valid   = 1'b0;
      rsp_in.out_byte     = 8'd0;
      if (cmd.commit) begin
         unique case (req_ff.op)
            OP_RX_PUT: begin
               rx_wp_in = rx_wp_inc;
            end
            OP_TX_READY: begin
               if (tx_rp_ff != tx_wp_ff) begin
                  rsp_in.byte_valid = 1'b1;
                  rsp_in.out_byte   = tx_rd_ff;
                  tx_rp_in          = tx_rp_inc;
               end else begin
                  irq_en_in = 1'b0;
               end
            end
            OP_TX_PUT: begin
               tx_wp_in = tx_wp_inc;
               if (req_ff.last_byte && req_ff.enable_transmit) begin
                  irq_en_in = 1'b1;
               end
            end
            OP_RX_GET: begin
               if (rx_rp_ff != rx_wp_ff) begin
                  rsp_in.byte_valid = 1'b1;
                  rsp_in.out_byte   = rx_rd_ff;
                  rx_rp_in          = rx_rp_inc;
               end
            end
            OP_CLEAR_ALL: begin
               rx_wp_in = '0;
               rx_rp_in = '0;
               tx_wp_in = '0;
               tx_rp_in = '0;
            end
            OP_CLEAR_TX: begin
               tx_wp_in = '0;
               tx_rp_in = '0;
            end
            default: begin
               // rx check and the unused code change no state
            end
         endcase
      end

      // Count waiting rx bytes after the operation
      if (rx_wp_in >= rx_rp_in) begin
         rx_count = RX_CW'(rx_wp_in) - RX_CW'(rx_rp_in);
      end else begin
         rx_count = RX_CW'(rx_wp_in) + RX_SIZE - RX_CW'(rx_rp_in);
      end
      rsp_in.rx_available = 8'(rx_count);
      rsp_in.enough_bytes = (req_ff.op == OP_RX_CHECK) && (rx_count != '0) &&
                            (CMP_W'(req_ff.wanted_count) <= CMP_W'(rx_count));
      rsp_in.tx_idle      = !irq_en_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_wp_ff  <= '0;
         rx_rp_ff  <= '0;
         tx_wp_ff  <= '0;
         tx_rp_ff  <= '0;
         irq_en_ff <= 1'b1;
      end else begin
         rx_wp_ff  <= rx_wp_in;
         rx_rp_ff  <= rx_rp_in;
         tx_wp_ff  <= tx_wp_in;
         tx_rp_ff  <= tx_rp_in;
         irq_en_ff <= irq_en_in;
      end
   end

   // Hold the result until the next commit
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_payload = rsp_ff;

endmodule

/* rtl/uart_dual_ring_buffer.sv */
// Top level: receive and transmit ring buffers for a serial port.
// Each transaction runs as capture with the ring memory read, then commit.
// The result comes from the result register, loaded at commit after the capture.
// A new request is not accepted until the previous transaction has committed.
// A new request is accepted while the previous result waits; commit holds until it is taken.
// Synchronous reset clears pointers, sets the transmit enable flag; ring memories keep contents.
module uart_dual_ring_buffer #(
   parameter int RX_DEPTH = 256,
   parameter int TX_DEPTH = 256
) (
   input  logic         clock,
   input  logic         reset,
   udrb_req_if.sink     req_ch,
   udrb_rsp_if.source   rsp_ch
);
   import udrb_pkg::*;

   ctrl_cmd_type cmd;

   udrb_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd)
   );

   udrb_datapath #(
      .RX_DEPTH (RX_DEPTH),
      .TX_DEPTH (TX_DEPTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_payload (req_ch.payload),
      .rsp_payload (rsp_ch.payload)
   );

endmodule

/* rtl/udrb_checker.sv */
// Port-level checker for the ring buffer pair, bound to the top level.
module udrb_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input udrb_pkg::rsp_type  rsp_payload
);
   import udrb_pkg::*;

   // A transaction occupies the block until its commit
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted during commit cycle");

   // With the result register free, the response follows the capture and the commit
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (!rsp_valid || rsp_ready)) |=> ##1 rsp_valid)
      else $error("response missing two cycles after acceptance");

   // A stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_payload)))
      else $error("stalled response changed");

   // Only byte operations fetch a byte, only rx check reports enough bytes
   a_excl_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_payload.byte_valid && rsp_payload.enough_bytes))
      else $error("byte and count flags both set");

endmodule

bind uart_dual_ring_buffer udrb_checker u_udrb_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rsp_payload (rsp_ch.payload)
);
